// ----- rtl/gla_pkg.sv -----
// ----------------------------------------------------------------------------
// gla_pkg
// Shared types, constants and helpers for the grid locate / advect block.
// ----------------------------------------------------------------------------
package gla_pkg;

  localparam int GridColsDefault   = 256;
  localparam int GridRowsDefault   = 256;
  localparam int ValueWidthDefault = 32;
  localparam int FieldWidth        = 32;
  localparam int IndexWidth        = 8;
  localparam int CmdWidth          = 2;
  localparam int CfgIndexWidth     = 3;

  typedef enum logic [CmdWidth-1:0] {
    CMD_LOAD_X   = 2'd0,
    CMD_LOAD_Y   = 2'd1,
    CMD_LOAD_VEL = 2'd2,
    CMD_POINT    = 2'd3
  } cmd_t;

  typedef enum logic [CfgIndexWidth-1:0] {
    REG_TIME_STEP = 3'd0,
    REG_FIRST_COL = 3'd1,
    REG_LAST_COL  = 3'd2,
    REG_FIRST_ROW = 3'd3,
    REG_LAST_ROW  = 3'd4
  } reg_index_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_XLO_REQ, ST_XLO_CHK,
    ST_XHI_REQ, ST_XHI_CHK,
    ST_XMID_REQ, ST_XMID_CHK,
    ST_YLO_REQ, ST_YLO_CHK,
    ST_YHI_REQ, ST_YHI_CHK,
    ST_YMID_REQ, ST_YMID_CHK,
    ST_CELL_REQ, ST_CELL_RD,
    ST_DIVX, ST_DIVY,
    ST_COEF, ST_VEL_REQ, ST_VEL_RD,
    ST_MAC, ST_STEP, ST_OUT
  } back_state_t;

  // queued command word between front and back
  typedef struct packed {
    cmd_t                   cmd;
    logic [IndexWidth-1:0]  col_index;
    logic [IndexWidth-1:0]  row_index;
    logic [FieldWidth-1:0]  first_value;
    logic [FieldWidth-1:0]  second_value;
  } item_t;

  // result word
  typedef struct packed {
    logic [IndexWidth-1:0]  cell_col;
    logic [IndexWidth-1:0]  cell_row;
    logic [FieldWidth-1:0]  weight_x;
    logic [FieldWidth-1:0]  weight_y;
    logic [FieldWidth-1:0]  moved_x;
    logic [FieldWidth-1:0]  moved_y;
  } result_t;

  // saturate a wide signed value to bits (<= 32) signed, returned in 32 bits
  function automatic logic signed [FieldWidth-1:0] sat_val(
      input logic signed [79:0] v, input int bits);
    logic signed [79:0] hi;
    logic signed [79:0] lo;
    hi = (80'sd1 <<< (bits - 1)) - 80'sd1;
    lo = -hi - 80'sd1;
    if (v > hi) sat_val = hi[FieldWidth-1:0];
    else if (v < lo) sat_val = lo[FieldWidth-1:0];
    else sat_val = v[FieldWidth-1:0];
  endfunction

endpackage

// ----- rtl/gla_if.sv -----
// ----------------------------------------------------------------------------
// gla_if
// Valid/ready channel carrying one payload word.
// ----------------------------------------------------------------------------
interface gla_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/gla_div.sv -----
// ----------------------------------------------------------------------------
// gla_div
// Restoring signed divider, one quotient bit per cycle, truncates toward zero.
// ----------------------------------------------------------------------------
module gla_div
  import gla_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [63:0] num,
  input  logic signed [63:0] den,
  output logic               done,
  output logic signed [63:0] quot
);

  logic [63:0] q;
  logic [63:0] rem;
  logic [63:0] dv;
  logic        neg;
  logic [6:0]  cnt;
  logic        busy;
  logic [64:0] trial;

  assign trial = {rem[63:0], q[63]} - {1'b0, dv};

  // one bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 7'd64;
        neg  <= num[63] ^ den[63];
        q    <= num[63] ? 64'(-num) : num;
        dv   <= den[63] ? 64'(-den) : den;
        rem  <= '0;
      end else if (busy) begin
        if (!trial[64]) begin
          rem <= trial[63:0];
          q   <= {q[62:0], 1'b1};
        end else begin
          rem <= {rem[62:0], q[63]};
          q   <= {q[62:0], 1'b0};
        end
        cnt <= cnt - 7'd1;
        if (cnt == 7'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quot = neg ? 64'(-q) : q;

endmodule

// ----- rtl/gla_front.sv -----
// ----------------------------------------------------------------------------
// gla_front
// Accepts command words, checks load indices, queues them for the back end.
// ----------------------------------------------------------------------------
module gla_front
  import gla_pkg::*;
#(
  parameter int GRID_COLS = GridColsDefault,
  parameter int GRID_ROWS = GridRowsDefault
) (
  input  logic  clk,
  input  logic  rst,
  gla_if.sink   in_ch,
  output item_t q_data,
  output logic  q_valid,
  input  logic  q_pop
);

  localparam int Depth = 4;

  item_t      mem [Depth];
  logic [1:0] wr_ptr;
  logic [1:0] rd_ptr;
  logic [2:0] count;
  logic       push;
  logic       keep;

  // loads outside the grid are dropped here
  always_comb begin
    unique case (in_ch.data.cmd)
      CMD_LOAD_X:   keep = 32'(in_ch.data.col_index) < GRID_COLS;
      CMD_LOAD_Y:   keep = 32'(in_ch.data.row_index) < GRID_ROWS;
      CMD_LOAD_VEL: keep = (32'(in_ch.data.col_index) < GRID_COLS) &&
                           (32'(in_ch.data.row_index) < GRID_ROWS);
      default:      keep = 1'b1;
    endcase
  end

  assign in_ch.ready = count != 3'(Depth);
  assign push        = in_ch.valid && in_ch.ready && keep;
  assign q_valid     = count != 3'd0;
  assign q_data      = mem[rd_ptr];

  // queue storage
  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= in_ch.data;
  end

  // queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 2'd1;
      if (q_pop) rd_ptr <= rd_ptr + 2'd1;
      count <= count + 3'(push) - 3'(q_pop);
    end
  end

endmodule

// ----- rtl/gla_back.sv -----
// ----------------------------------------------------------------------------
// gla_back
// Executes queued words: table writes, bisection, weights, interpolation, step.
// ----------------------------------------------------------------------------
module gla_back
  import gla_pkg::*;
#(
  parameter int GRID_COLS   = GridColsDefault,
  parameter int GRID_ROWS   = GridRowsDefault,
  parameter int VALUE_WIDTH = ValueWidthDefault
) (
  input  logic                   clk,
  input  logic                   rst,
  input  item_t                  q_data,
  input  logic                   q_valid,
  output logic                   q_pop,
  input  logic signed [31:0]     time_step,
  input  logic [IndexWidth-1:0]  first_col,
  input  logic [IndexWidth-1:0]  last_col,
  input  logic [IndexWidth-1:0]  first_row,
  input  logic [IndexWidth-1:0]  last_row,
  gla_if.source                  out_ch
);

  localparam int CW   = $clog2(GRID_COLS);
  localparam int RW   = $clog2(GRID_ROWS);
  localparam int VW   = $clog2(GRID_COLS*GRID_ROWS);
  localparam int SatW = (VALUE_WIDTH > 32) ? 32 : VALUE_WIDTH;

  // tables
  logic signed [31:0] xtab [GRID_COLS];
  logic signed [31:0] ytab [GRID_ROWS];
  logic signed [31:0] vxm  [GRID_COLS*GRID_ROWS];
  logic signed [31:0] vym  [GRID_COLS*GRID_ROWS];

  back_state_t state, state_next;

  logic [CW-1:0]       xa;
  logic [RW-1:0]       ya;
  logic [VW-1:0]       va;
  logic [VW-1:0]       wa;
  logic signed [31:0]  xrd, yrd, vxrd, vyrd;
  logic                vwe;

  logic [CW-1:0]       clo, chi;
  logic [RW-1:0]       rlo, rhi;
  logic signed [31:0]  px, py;
  logic signed [31:0]  x0, x1, y0, y1;
  logic signed [31:0]  wx, wy;
  logic signed [31:0]  cf [4];
  logic signed [31:0]  ux, uy;
  logic signed [63:0]  accx, accy;
  logic [1:0]          k;
  logic                phase;
  result_t             res;
  logic                out_valid;

  logic                div_start, div_done;
  logic signed [63:0]  div_num, div_den, div_q;

  gla_div u_div (
    .clk (clk), .rst (rst), .start (div_start),
    .num (div_num), .den (div_den), .done (div_done), .quot (div_q)
  );

  // clamped bounds
  logic [31:0] fcs, lcs, frs, lrs;
  always_comb begin
    fcs = (32'(first_col) > 32'(GRID_COLS - 2)) ? 32'(GRID_COLS - 2) : 32'(first_col);
    lcs = (32'(last_col) > 32'(GRID_COLS - 1)) ? 32'(GRID_COLS - 1) : 32'(last_col);
    if (lcs <= fcs) lcs = fcs + 32'd1;
    frs = (32'(first_row) > 32'(GRID_ROWS - 2)) ? 32'(GRID_ROWS - 2) : 32'(first_row);
    lrs = (32'(last_row) > 32'(GRID_ROWS - 1)) ? 32'(GRID_ROWS - 1) : 32'(last_row);
    if (lrs <= frs) lrs = frs + 32'd1;
  end

  logic [CW-1:0] cmid;
  logic [RW-1:0] rmid;
  assign cmid = CW'(({1'b0, clo} + {1'b0, chi}) >> 1);
  assign rmid = RW'(({1'b0, rlo} + {1'b0, rhi}) >> 1);

  // row-major velocity write address
  assign wa = VW'(q_data.row_index) * VW'(GRID_COLS) + VW'(q_data.col_index);

  // table writes and registered reads
  assign vwe = (state == ST_IDLE) && q_valid && (q_data.cmd == CMD_LOAD_VEL);
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && q_valid && q_data.cmd == CMD_LOAD_X)
      xtab[CW'(q_data.col_index)] <= q_data.first_value;
    if (state == ST_IDLE && q_valid && q_data.cmd == CMD_LOAD_Y)
      ytab[RW'(q_data.row_index)] <= q_data.first_value;
    xrd <= xtab[xa];
    yrd <= ytab[ya];
  end

  always_ff @(posedge clk) begin
    if (vwe) vxm[wa] <= q_data.first_value;
    vxrd <= vxm[va];
  end

  always_ff @(posedge clk) begin
    if (vwe) vym[wa] <= q_data.second_value;
    vyrd <= vym[va];
  end

  // read addresses
  always_comb begin
    xa = clo;
    ya = rlo;
    va = VW'(rlo + RW'(k[1])) * VW'(GRID_COLS) + VW'(clo + CW'(k[0]));
    unique case (state)
      ST_XHI_REQ:  xa = chi;
      ST_XMID_REQ: xa = cmid;
      ST_YHI_REQ:  ya = rhi;
      ST_YMID_REQ: ya = rmid;
      ST_CELL_REQ: begin
        xa = phase ? clo + CW'(1) : clo;
        ya = phase ? rlo + RW'(1) : rlo;
      end
      default: ;
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    div_start  = 1'b0;
    div_num    = '0;
    div_den    = 64'sd1;
    unique case (state)
      ST_IDLE: if (q_valid) begin
        q_pop = 1'b1;
        if (q_data.cmd == CMD_POINT) state_next = ST_XLO_REQ;
      end
      ST_XLO_REQ:  state_next = ST_XLO_CHK;
      ST_XLO_CHK:  state_next = ST_XHI_REQ;
      ST_XHI_REQ:  state_next = ST_XHI_CHK;
      ST_XHI_CHK:  state_next = ST_XMID_REQ;
      ST_XMID_REQ: state_next = ST_XMID_CHK;
      ST_XMID_CHK: state_next = ST_XMID_REQ;
      ST_YLO_REQ:  state_next = ST_YLO_CHK;
      ST_YLO_CHK:  state_next = ST_YHI_REQ;
      ST_YHI_REQ:  state_next = ST_YHI_CHK;
      ST_YHI_CHK:  state_next = ST_YMID_REQ;
      ST_YMID_REQ: state_next = ST_YMID_CHK;
      ST_YMID_CHK: state_next = ST_YMID_REQ;
      ST_CELL_REQ: state_next = ST_CELL_RD;
      ST_CELL_RD: begin
        if (phase) begin
          // x weight division starts once the upper x corner is read
          div_start  = 1'b1;
          div_num    = (64'(px) - 64'(x0)) <<< 16;
          div_den    = 64'(xrd) - 64'(x0);
          state_next = ST_DIVX;
        end else begin
          state_next = ST_CELL_REQ;
        end
      end
      ST_DIVX: if (div_done) begin
        // y weight division follows right away
        div_start  = 1'b1;
        div_num    = (64'(py) - 64'(y0)) <<< 16;
        div_den    = 64'(y1) - 64'(y0);
        state_next = ST_DIVY;
      end
      ST_DIVY:    if (div_done) state_next = ST_COEF;
      ST_COEF:    state_next = ST_VEL_REQ;
      ST_VEL_REQ: state_next = ST_VEL_RD;
      ST_VEL_RD:  state_next = ST_MAC;
      ST_MAC:     state_next = (k == 2'd3) ? ST_STEP : ST_VEL_REQ;
      ST_STEP:    state_next = phase ? ST_OUT : ST_STEP;
      ST_OUT:     if (out_ch.ready) state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
    // bisection exits depend on fetched data and on the remaining span
    if (state == ST_XLO_CHK && 64'(px) <= 64'(xrd)) state_next = ST_YLO_REQ;
    if (state == ST_XHI_CHK && 64'(px) >= 64'(xrd)) state_next = ST_YLO_REQ;
    if (state == ST_XHI_CHK && !(64'(px) >= 64'(xrd)) && 32'(chi) - 32'(clo) <= 32'd1)
      state_next = ST_YLO_REQ;
    if (state == ST_XMID_CHK && 32'(chi) - 32'(clo) <= 32'd2) state_next = ST_YLO_REQ;
    if (state == ST_YLO_CHK && 64'(py) <= 64'(yrd)) state_next = ST_CELL_REQ;
    if (state == ST_YHI_CHK && 64'(py) >= 64'(yrd)) state_next = ST_CELL_REQ;
    if (state == ST_YHI_CHK && !(64'(py) >= 64'(yrd)) && 32'(rhi) - 32'(rlo) <= 32'd1)
      state_next = ST_CELL_REQ;
    if (state == ST_YMID_CHK && 32'(rhi) - 32'(rlo) <= 32'd2) state_next = ST_CELL_REQ;
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  // datapath
  logic signed [63:0] umx, umy;
  logic signed [31:0] vsel_x, vsel_y;
  always_comb begin
    umx = 64'sd65536 - 64'(wx);
    umy = 64'sd65536 - 64'(wy);
    vsel_x = vxrd;
    vsel_y = vyrd;
  end

  logic signed [63:0] mulx, muly;
  assign mulx = 64'(cf[k]) * 64'(vsel_x);
  assign muly = 64'(cf[k]) * 64'(vsel_y);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      phase     <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: if (q_valid && q_data.cmd == CMD_POINT) begin
          px <= q_data.first_value;
          py <= q_data.second_value;
          clo <= CW'(fcs);
          chi <= CW'(lcs);
          rlo <= RW'(frs);
          rhi <= RW'(lrs);
          phase <= 1'b0;
        end
        ST_XLO_CHK: if (64'(px) <= 64'(xrd)) chi <= clo + CW'(1);
        ST_XHI_CHK: if (64'(px) >= 64'(xrd)) clo <= chi - CW'(1);
        ST_XMID_CHK: begin
          if (64'(px) < 64'(xrd)) chi <= cmid;
          else clo <= cmid;
        end
        ST_YLO_CHK: if (64'(py) <= 64'(yrd)) rhi <= rlo + RW'(1);
        ST_YHI_CHK: if (64'(py) >= 64'(yrd)) rlo <= rhi - RW'(1);
        ST_YMID_CHK: begin
          if (64'(py) < 64'(yrd)) rhi <= rmid;
          else rlo <= rmid;
        end
        ST_CELL_RD: begin
          // first pass: lower cell corners, second pass: upper cell corners
          if (!phase) begin
            x0 <= xrd;
            y0 <= yrd;
            phase <= 1'b1;
          end else begin
            x1 <= xrd;
            y1 <= yrd;
            phase <= 1'b0;
          end
        end
        ST_DIVX: if (div_done) begin
          wx <= (x1 == x0) ? 32'sd0 : sat_val(80'(div_q), SatW);
        end
        ST_DIVY: if (div_done) begin
          wy <= (y1 == y0) ? 32'sd0 : sat_val(80'(div_q), SatW);
        end
        ST_COEF: begin
          cf[0] <= sat_val(80'((umx * umy) >>> 16), SatW);
          cf[1] <= sat_val(80'((64'(wx) * umy) >>> 16), SatW);
          cf[2] <= sat_val(80'((umx * 64'(wy)) >>> 16), SatW);
          cf[3] <= sat_val(80'((64'(wx) * 64'(wy)) >>> 16), SatW);
          k    <= 2'd0;
          accx <= '0;
          accy <= '0;
        end
        ST_MAC: begin
          accx <= accx + (mulx >>> 16);
          accy <= accy + (muly >>> 16);
          k    <= k + 2'd1;
        end
        ST_STEP: begin
          if (!phase) begin
            ux <= sat_val(80'(accx), SatW);
            uy <= sat_val(80'(accy), SatW);
            phase <= 1'b1;
          end else begin
            res.cell_col <= IndexWidth'(clo);
            res.cell_row <= IndexWidth'(rlo);
            res.weight_x <= wx;
            res.weight_y <= wy;
            res.moved_x  <= sat_val(80'(64'(px) + ((64'(time_step) * 64'(ux)) >>> 16)), SatW);
            res.moved_y  <= sat_val(80'(64'(py) + ((64'(time_step) * 64'(uy)) >>> 16)), SatW);
            phase <= 1'b0;
            out_valid <= 1'b1;
          end
        end
        ST_OUT: if (out_ch.ready) out_valid <= 1'b0;
        default: ;
      endcase
    end
  end

  assign out_ch.valid = out_valid;
  assign out_ch.data  = res;

endmodule

// ----- rtl/grid_locate_bilinear_advect.sv -----
// a point word's processing time is set by the two bisections (a request and a check state
// per probe), the two serial divisions and output stalls
// the back end handles one point at a time and writes load words into its tables while idle
// a four-word queue lets input be taken while the back end works
// reset: synchronous active-high rst clears control and config to defaults;
// coordinate and velocity tables are undefined until written
module grid_locate_bilinear_advect
  import gla_pkg::*;
#(
  parameter int GRID_COLS   = GridColsDefault,
  parameter int GRID_ROWS   = GridRowsDefault,
  parameter int VALUE_WIDTH = ValueWidthDefault
) (
  input  logic clk,
  input  logic rst,
  gla_if.sink   in_ch,
  gla_if.source out_ch,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CfgIndexWidth-1:0]  cfg_index,
  input  logic [FieldWidth-1:0]     cfg_data
);

  logic signed [31:0]    time_step;
  logic [IndexWidth-1:0] first_col, last_col, first_row, last_row;
  item_t                 q_data;
  logic                  q_valid, q_pop;

  assign cfg_ready = 1'b1;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      time_step <= '0;
      first_col <= '0;
      last_col  <= '1;
      first_row <= '0;
      last_row  <= '1;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_TIME_STEP: time_step <= cfg_data;
        REG_FIRST_COL: first_col <= cfg_data[IndexWidth-1:0];
        REG_LAST_COL:  last_col  <= cfg_data[IndexWidth-1:0];
        REG_FIRST_ROW: first_row <= cfg_data[IndexWidth-1:0];
        REG_LAST_ROW:  last_row  <= cfg_data[IndexWidth-1:0];
        default: ;
      endcase
    end
  end

  gla_front #(.GRID_COLS(GRID_COLS), .GRID_ROWS(GRID_ROWS)) u_front (
    .clk (clk), .rst (rst), .in_ch (in_ch),
    .q_data (q_data), .q_valid (q_valid), .q_pop (q_pop)
  );

  gla_back #(.GRID_COLS(GRID_COLS), .GRID_ROWS(GRID_ROWS),
             .VALUE_WIDTH(VALUE_WIDTH)) u_back (
    .clk (clk), .rst (rst), .q_data (q_data), .q_valid (q_valid), .q_pop (q_pop),
    .time_step (time_step), .first_col (first_col), .last_col (last_col),
    .first_row (first_row), .last_row (last_row), .out_ch (out_ch)
  );

endmodule

// ----- rtl/gla_checker.sv -----
// ----------------------------------------------------------------------------
// gla_checker
// Port-level checks on the grid locate / advect block.
// ----------------------------------------------------------------------------
module gla_checker
  import gla_pkg::*;
(
  input logic    clk,
  input logic    rst,
  input logic    out_valid,
  input logic    out_ready,
  input result_t out_data,
  input logic    in_ready
);

  // a result word holds until taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");

  // a waiting result word keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_data)) else $error("result changed");

  // no result right after reset
  a_reset_quiet: assert property (@(posedge clk)
    $past(rst) |-> !out_valid) else $error("result after reset");

  // queue accepts after reset
  a_ready_reset: assert property (@(posedge clk)
    $past(rst) |-> in_ready) else $error("not ready after reset");

endmodule

bind grid_locate_bilinear_advect gla_checker u_gla_checker (
  .clk (clk), .rst (rst),
  .out_valid (out_ch.valid), .out_ready (out_ch.ready), .out_data (out_ch.data),
  .in_ready (in_ch.ready)
);

// ----- test/testbench.sv -----
// ----------------------------------------------------------------------------
// grid_locate_bilinear_advect testbench
// Drives load and point words through the valid/ready channels and checks
// every result word against a fixed word or an in-bench model of the cell
// search, the bilinear velocity interpolation and the advection step. The
// test starts with a directed table, then runs randomized phases over
// small grid windows with different register settings and idle patterns.
// ----------------------------------------------------------------------------
module testbench;
  import gla_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IdleLimit = 4000;
  localparam int DrainCycles = 200;

  logic clk = 1'b0;
  logic rst;
  logic cfg_valid;
  logic cfg_ready;
  logic [CfgIndexWidth-1:0] cfg_index;
  logic [FieldWidth-1:0] cfg_data;

  gla_if #(.payload_t(item_t)) in_ch ();
  gla_if #(.payload_t(result_t)) out_ch ();

  grid_locate_bilinear_advect DUT (
    .clk(clk),
    .rst(rst),
    .in_ch(in_ch),
    .out_ch(out_ch),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // model state
  int x_tab [256];
  int y_tab [256];
  int vel_x [65536];
  int vel_y [65536];
  longint step_q;
  int first_col_q, last_col_q, first_row_q, last_row_q;

  result_t expected_results [$];
  int mismatches = 0;
  int send_pct = 0;
  int stall_pct = 0;

  // directed rows
  typedef struct {
    item_t   word;
    bit      typed;
    result_t want;
  } row_t;
  row_t rows [$];

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint floor_q16(longint v);
    return v >>> 16;
  endfunction

  // effective index window after register clamping
  function automatic void clamp_window(int first, int last, output int lo, output int hi);
    lo = (first > 254) ? 254 : first;
    hi = (last > 255) ? 255 : last;
    if (hi <= lo) hi = lo + 1;
  endfunction

  // cell search by bisection on one axis
  function automatic int find_cell(longint v, bit on_y, int lo, int hi);
    int mid;
    longint t;
    t = on_y ? y_tab[lo] : x_tab[lo];
    if (v <= t) return lo;
    t = on_y ? y_tab[hi] : x_tab[hi];
    if (v >= t) return hi - 1;
    while (hi - lo > 1) begin
      mid = (lo + hi) >> 1;
      t = on_y ? y_tab[mid] : x_tab[mid];
      if (v < t) hi = mid;
      else lo = mid;
    end
    return lo;
  endfunction

  function automatic longint cell_weight(longint v, longint c0, longint c1);
    longint w;
    w = c1 - c0;
    if (w == 0) return 0;
    return sat32(((v - c0) * 65536) / w);
  endfunction

  // applies one word to the model; returns 1 with the result for a point
  function automatic bit model_word(item_t it, output result_t res);
    int clo, chi, rlo, rhi, i, j, k00, k10, k01, k11;
    longint px, py, wx, wy, umx, umy, ux, uy;
    longint c [4];
    res = '0;
    case (it.cmd)
      CMD_LOAD_X: begin
        x_tab[it.col_index] = $signed(it.first_value);
        return 1'b0;
      end
      CMD_LOAD_Y: begin
        y_tab[it.row_index] = $signed(it.first_value);
        return 1'b0;
      end
      CMD_LOAD_VEL: begin
        vel_x[{it.row_index, it.col_index}] = $signed(it.first_value);
        vel_y[{it.row_index, it.col_index}] = $signed(it.second_value);
        return 1'b0;
      end
      default: ;
    endcase
    px = longint'($signed(it.first_value));
    py = longint'($signed(it.second_value));
    clamp_window(first_col_q, last_col_q, clo, chi);
    clamp_window(first_row_q, last_row_q, rlo, rhi);
    i = find_cell(px, 1'b0, clo, chi);
    j = find_cell(py, 1'b1, rlo, rhi);
    wx = cell_weight(px, x_tab[i], x_tab[i+1]);
    wy = cell_weight(py, y_tab[j], y_tab[j+1]);
    umx = 65536 - wx;
    umy = 65536 - wy;
    c[0] = sat32(floor_q16(umx * umy));
    c[1] = sat32(floor_q16(wx * umy));
    c[2] = sat32(floor_q16(umx * wy));
    c[3] = sat32(floor_q16(wx * wy));
    k00 = j * 256 + i;
    k10 = k00 + 1;
    k01 = k00 + 256;
    k11 = k01 + 1;
    ux = sat32(floor_q16(c[0] * vel_x[k00]) + floor_q16(c[1] * vel_x[k10])
             + floor_q16(c[2] * vel_x[k01]) + floor_q16(c[3] * vel_x[k11]));
    uy = sat32(floor_q16(c[0] * vel_y[k00]) + floor_q16(c[1] * vel_y[k10])
             + floor_q16(c[2] * vel_y[k01]) + floor_q16(c[3] * vel_y[k11]));
    res.cell_col = i[7:0];
    res.cell_row = j[7:0];
    res.weight_x = wx[31:0];
    res.weight_y = wy[31:0];
    res.moved_x = 32'(sat32(px + floor_q16(step_q * ux)));
    res.moved_y = 32'(sat32(py + floor_q16(step_q * uy)));
    return 1'b1;
  endfunction

  function automatic item_t make_word(cmd_t cmd, int col, int row, logic [31:0] v1,
                                      logic [31:0] v2);
    item_t it;
    it.cmd = cmd;
    it.col_index = col[7:0];
    it.row_index = row[7:0];
    it.first_value = v1;
    it.second_value = v2;
    return it;
  endfunction

  function automatic void add_row(item_t it, bit typed = 1'b0, result_t want = '0);
    row_t r;
    r.word = it;
    r.typed = typed;
    r.want = want;
    rows.insert(rows.size(), r);
  endfunction

  // send one word; valid stays high after acceptance
  task automatic send_word(item_t it, bit typed = 1'b0, result_t want = '0);
    result_t res;
    while ($urandom_range(99) < send_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= it;
    do @(posedge clk); while (!in_ch.ready);
    if (model_word(it, res))
      expected_results.insert(expected_results.size(), typed ? want : res);
  endtask

  task automatic write_reg(reg_index_t idx, logic [31:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_TIME_STEP: step_q = longint'($signed(d));
      REG_FIRST_COL: first_col_q = d[7:0];
      REG_LAST_COL:  last_col_q = d[7:0];
      REG_FIRST_ROW: first_row_q = d[7:0];
      default:       last_row_q = d[7:0];
    endcase
  endtask

  task automatic write_regs(logic [31:0] ts, int fc, int lc, int fr, int lr);
    write_reg(REG_TIME_STEP, ts);
    write_reg(REG_FIRST_COL, fc);
    write_reg(REG_LAST_COL, lc);
    write_reg(REG_FIRST_ROW, fr);
    write_reg(REG_LAST_ROW, lr);
    cfg_valid <= 1'b0;
  endtask

  // sender pauses until all results are back, then lets the back end settle
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_value();
    case ($urandom_range(3))
      0: return $urandom();
      1: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
      default: return $signed($urandom_range(32'h00100000)) - 32'sh00080000;
    endcase
  endfunction

  // result checking
  initial begin
    result_t got, exp;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_ch.valid && out_ch.ready) begin
        got = out_ch.data;
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result word %h", got);
        end else begin
          exp = expected_results.pop_front();
          if (got.cell_col !== exp.cell_col || got.cell_row !== exp.cell_row ||
              got.weight_x !== exp.weight_x || got.weight_y !== exp.weight_y ||
              got.moved_x !== exp.moved_x || got.moved_y !== exp.moved_y) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: cell %0d,%0d w %h,%0h moved %h,%h / got %0d,%0d w %h,%h moved %h,%h",
                       exp.cell_col, exp.cell_row, exp.weight_x, exp.weight_y,
                       exp.moved_x, exp.moved_y, got.cell_col, got.cell_row,
                       got.weight_x, got.weight_y, got.moved_x, got.moved_y);
          end
        end
      end
      out_ch.ready <= rst ? 1'b0 : ($urandom_range(99) >= stall_pct);
    end
  end

  // watchdog on cycles with no handshake at all
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("grid_locate_bilinear_advect regression: fail");
        $finish;
      end
    end
  end

  // stimulus
  initial begin
    int clo, chi, rlo, rhi, span, fc, fr, k;
    longint base;
    logic [31:0] pxv, pyv;
    item_t it;
    rst <= 1'b1;
    cfg_valid <= 1'b0;
    cfg_index <= REG_TIME_STEP;
    cfg_data <= '0;
    in_ch.valid <= 1'b0;
    in_ch.data <= '0;
    step_q = 0;
    first_col_q = 0;
    last_col_q = 255;
    first_row_q = 0;
    last_row_q = 255;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: 2x2 window, first with flat cells and still field, then extremes
    write_regs(32'h00010000, 0, 1, 0, 1);
    add_row(make_word(CMD_LOAD_X, 0, 0, 32'h0, 32'h0));
    add_row(make_word(CMD_LOAD_X, 1, 0, 32'h0, 32'h0));
    add_row(make_word(CMD_LOAD_Y, 0, 0, 32'h0, 32'h0));
    add_row(make_word(CMD_LOAD_Y, 0, 1, 32'h0, 32'h0));
    add_row(make_word(CMD_LOAD_VEL, 0, 0, 32'h0, 32'h0));
    add_row(make_word(CMD_LOAD_VEL, 1, 0, 32'h0, 32'h0));
    add_row(make_word(CMD_LOAD_VEL, 0, 1, 32'h0, 32'h0));
    add_row(make_word(CMD_LOAD_VEL, 1, 1, 32'h0, 32'h0));
    // zero-width cells and zero velocity: point stays put, weights zero
    add_row(make_word(CMD_POINT, 0, 0, 32'h00050000, 32'hfffd0000), 1'b1,
            {8'd0, 8'd0, 32'h0, 32'h0, 32'h00050000, 32'hfffd0000});
    add_row(make_word(CMD_LOAD_X, 1, 0, 32'h00010000, 32'h0));
    add_row(make_word(CMD_LOAD_Y, 0, 1, 32'h00020000, 32'h0));
    add_row(make_word(CMD_LOAD_VEL, 0, 0, 32'h7fffffff, 32'h80000000));
    add_row(make_word(CMD_LOAD_VEL, 1, 0, 32'h80000000, 32'h7fffffff));
    add_row(make_word(CMD_LOAD_VEL, 0, 1, 32'h00010000, 32'hffff0000));
    add_row(make_word(CMD_LOAD_VEL, 1, 1, 32'h0, 32'h12345678));
    add_row(make_word(CMD_POINT, 255, 255, 32'h00008000, 32'h00010000));
    add_row(make_word(CMD_POINT, 0, 0, 32'h80000000, 32'h80000000));
    add_row(make_word(CMD_POINT, 0, 0, 32'h7fffffff, 32'h7fffffff));
    add_row(make_word(CMD_POINT, 0, 0, 32'h0, 32'h0));
    add_row(make_word(CMD_POINT, 0, 0, 32'h00010000, 32'h00020000));
    add_row(make_word(CMD_LOAD_X, 255, 0, 32'h7fffffff, 32'hffffffff));
    add_row(make_word(CMD_LOAD_Y, 0, 255, 32'h80000000, 32'hffffffff));
    add_row(make_word(CMD_LOAD_VEL, 255, 255, 32'hffffffff, 32'hffffffff));
    add_row(make_word(CMD_POINT, 170, 85, 32'h0000c000, 32'hffffffff));
    foreach (rows[r]) send_word(rows[r].word, rows[r].typed, rows[r].want);

    // random phases over small grid windows
    for (int ph = 0; ph < 10; ph++) begin
      drain();
      send_pct = 0;
      stall_pct = 0;
      span = (ph == 3) ? 15 : $urandom_range(1, 6);
      fc = $urandom_range(255);
      fr = $urandom_range(255);
      case (ph)
        0: write_regs(32'h80000000, 255, 255, 0, 0);
        1: write_regs(32'h7fffffff, 0, 1, 254, 255);
        2: write_regs(32'h0, 200, 100, fr, fr + span);
        default: write_regs(rand_value(), fc, fc + span, fr, fr + span);
      endcase
      case (ph % 4)
        1: send_pct = 63;
        2: stall_pct = 63;
        3: begin
          send_pct = 17;
          stall_pct = 17;
        end
        default: ;
      endcase
      clamp_window(first_col_q, last_col_q, clo, chi);
      clamp_window(first_row_q, last_row_q, rlo, rhi);

      // coordinates mostly ascending, sometimes flat or arbitrary
      base = $signed($urandom_range(32'h00400000)) - 32'sh00200000;
      for (k = clo; k <= chi; k++) begin
        send_word(make_word(CMD_LOAD_X, k, $urandom_range(255),
                            ($urandom_range(15) == 0) ? $urandom() : base[31:0], $urandom()));
        base += ($urandom_range(4) == 0) ? 0 : $urandom_range(1, 32'h00040000);
      end
      base = $signed($urandom_range(32'h00400000)) - 32'sh00200000;
      for (k = rlo; k <= rhi; k++) begin
        send_word(make_word(CMD_LOAD_Y, $urandom_range(255), k,
                            ($urandom_range(15) == 0) ? $urandom() : base[31:0], $urandom()));
        base += ($urandom_range(4) == 0) ? 0 : $urandom_range(1, 32'h00040000);
      end
      for (int rr = rlo; rr <= rhi; rr++)
        for (int cc = clo; cc <= chi; cc++)
          send_word(make_word(CMD_LOAD_VEL, cc, rr, rand_value(), rand_value()));

      // points near the grid lines, a few anywhere, with reloads mixed in
      for (int n = 0; n < 130; n++) begin
        if ($urandom_range(5) == 0) begin
          it = make_word(cmd_t'($urandom_range(2)), $urandom_range(clo, chi),
                         $urandom_range(rlo, rhi), rand_value(), rand_value());
        end else begin
          pxv = x_tab[$urandom_range(clo, chi)] + $signed($urandom_range(32'h60000)) - 32'sh30000;
          pyv = y_tab[$urandom_range(rlo, rhi)] + $signed($urandom_range(32'h60000)) - 32'sh30000;
          if ($urandom_range(9) == 0) pxv = $urandom();
          if ($urandom_range(9) == 0) pyv = $urandom();
          it = make_word(CMD_POINT, $urandom_range(255), $urandom_range(255), pxv, pyv);
        end
        send_word(it);
      end
    end

    drain();
    if (mismatches == 0 && expected_results.size() == 0)
      $display("grid_locate_bilinear_advect regression: pass");
    else
      $display("grid_locate_bilinear_advect regression: fail");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/gla_pkg.sv
rtl/gla_if.sv
rtl/gla_div.sv
rtl/gla_front.sv
rtl/gla_back.sv
rtl/grid_locate_bilinear_advect.sv
rtl/gla_checker.sv
test/testbench.sv
